[rtl/core/rmv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rmv_pkg;

  // fixed field widths of the item and result
  localparam int CH_BITS       = 6;
  localparam int INDEX_BITS    = 32;
  localparam int SAMPLE_BITS   = 32;
  localparam int COUNT_BITS    = INDEX_BITS + 1;
  localparam int MEAN_OUT_BITS = 32;
  localparam int SQ_BITS       = 63;
  localparam int PROD_BITS     = 64;

  // multiplier digit width and queue depth
  localparam int MUL_DIGIT   = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SQ_BITS-1:0] SQ_MAX = {SQ_BITS{1'b1}};

  // one classified item, as it travels from front to back
  typedef struct packed {
    logic [CH_BITS-1:0]            channel;
    logic                          live;
    logic [COUNT_BITS-1:0]         count;
    logic signed [SAMPLE_BITS-1:0] sample_value;
  } rmv_item_t;

endpackage

`default_nettype wire

[rtl/core/rmv_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rmv_front
  import rmv_pkg::*;
#(
  parameter int CHANNELS = 64
) (
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [CH_BITS-1:0]            in_channel,
  input  wire logic [INDEX_BITS-1:0]         in_sample_index,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  wire logic                          q_full,
  input  wire logic                          clearing,
  output logic                               push,
  output rmv_item_t                          push_item
);

  // hold off while the queue is full or the store is being cleared
  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    push_item.channel      = in_channel;
    push_item.live         = (32'(in_channel) < CHANNELS);
    push_item.count        = COUNT_BITS'(in_sample_index) + COUNT_BITS'(1);
    push_item.sample_value = in_sample_value;
  end

endmodule

`default_nettype wire

[rtl/core/rmv_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module rmv_queue
  import rmv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire rmv_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           pop_valid,
  output rmv_item_t      pop_item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  rmv_item_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;

  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/rmv_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rmv_back
  import rmv_pkg::*;
#(
  parameter int CHANNELS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     pop_valid,
  input  wire rmv_item_t                pop_item,
  output logic                          pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [CH_BITS-1:0]            out_channel_out,
  output logic signed [MEAN_OUT_BITS-1:0] out_mean_out,
  output logic [SQ_BITS-1:0]            out_sq_dev_sum_out,
  output logic                          out_saturated
);

  localparam int DW  = VALUE_BITS + 1;
  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ND  = (DW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int BPW = ND * MUL_DIGIT;
  localparam int PW  = DW + BPW;
  localparam int PWE = (PW > PROD_BITS) ? PW : PROD_BITS + 1;
  localparam int MW  = (VALUE_BITS > MEAN_OUT_BITS) ? VALUE_BITS : MEAN_OUT_BITS;
  localparam int DCW = $clog2(DW);
  localparam int MCW = (ND > 1) ? $clog2(ND) : 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_ADJ,
    ST_BDIF,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_t;

  state_t                       state_r;
  logic [CW-1:0]                clr_idx_r;
  logic [CW-1:0]                ch_idx_r;
  logic [CH_BITS-1:0]           ch_r;
  logic                         live_r;
  logic [COUNT_BITS-1:0]        n_r;
  logic signed [VALUE_BITS-1:0] x_r;
  logic signed [VALUE_BITS-1:0] m_r;
  logic signed [VALUE_BITS-1:0] m2_r;
  logic signed [VALUE_BITS-1:0] mean_rd_r;
  logic [SQ_BITS-1:0]           sq_rd_r;
  logic [SQ_BITS-1:0]           s_r;
  logic [SQ_BITS-1:0]           s2_r;
  logic                         sat_r;
  logic                         neg_r;
  logic [DW-1:0]                a_r;
  logic [DW-1:0]                quot_r;
  logic [COUNT_BITS-1:0]        rem_r;
  logic [DCW-1:0]               div_cnt_r;
  logic [MCW-1:0]               mul_cnt_r;
  logic [BPW-1:0]               mul_b_r;
  logic [PW-1:0]                acc_r;

  logic                         out_valid_r;
  logic [CH_BITS-1:0]           out_ch_r;
  logic signed [MEAN_OUT_BITS-1:0] out_mean_r;
  logic [SQ_BITS-1:0]           out_sq_r;
  logic                         out_sat_r;

  logic signed [VALUE_BITS-1:0] mean_mem [CHANNELS];
  logic [SQ_BITS-1:0]           sq_mem   [CHANNELS];

  logic [CW-1:0]                rd_idx;
  logic signed [VALUE_BITS-1:0] x_in;
  logic signed [VALUE_BITS-1:0] m_cur;
  logic [SQ_BITS-1:0]           s_cur;
  logic signed [DW-1:0]         d1;
  logic [DW-1:0]                a_mag;
  logic [COUNT_BITS:0]          rem_shift;
  logic [COUNT_BITS:0]          rem_sub;
  logic                         div_ge;
  logic signed [VALUE_BITS-1:0] m2_calc;
  logic signed [DW-1:0]         diff_b;
  logic [DW-1:0]                b_mag;
  logic [DW+MUL_DIGIT-1:0]      pp;
  logic [PW-1:0]                acc_step;
  logic [PWE-1:0]               prod_ext;
  logic                         sat_mul;
  logic [PROD_BITS:0]           sum_w;
  logic                         sat_sum;
  logic signed [MW-1:0]         m2_ext;
  logic                         out_free;
  logic                         mem_we;
  logic [CW-1:0]                mem_wa;
  logic signed [VALUE_BITS-1:0] mean_wd;
  logic [SQ_BITS-1:0]           sq_wd;

  assign clearing = (state_r == ST_CLEAR);
  assign pop      = (state_r == ST_IDLE) && pop_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign rd_idx   = CW'(pop_item.channel);
  assign x_in     = VALUE_BITS'(pop_item.sample_value);

  // old pair, zero for channels outside the store
  assign m_cur = live_r ? mean_rd_r : '0;
  assign s_cur = live_r ? sq_rd_r : '0;
  assign d1    = DW'(x_r) - DW'(m_cur);
  assign a_mag = d1[DW-1] ? DW'(-d1) : DW'(d1);

  // restoring divider step, one quotient bit per cycle
  assign rem_shift = {rem_r, quot_r[DW-1]};
  assign rem_sub   = rem_shift - {1'b0, n_r};
  assign div_ge    = (rem_shift >= {1'b0, n_r});

  assign m2_calc = VALUE_BITS'(neg_r ? (DW'(m_r) - quot_r) : (DW'(m_r) + quot_r));
  assign diff_b  = DW'(x_r) - DW'(m2_r);
  assign b_mag   = diff_b[DW-1] ? DW'(-diff_b) : DW'(diff_b);

  // digit multiplier, most significant digit first
  assign pp       = a_r * mul_b_r[BPW-1 -: MUL_DIGIT];
  assign acc_step = (acc_r << MUL_DIGIT) + PW'(pp);

  // saturating accumulate
  assign prod_ext = PWE'(acc_r);
  assign sat_mul  = |prod_ext[PWE-1:PROD_BITS];
  assign sum_w    = {1'b0, prod_ext[PROD_BITS-1:0]} + {2'b00, s_r};
  assign sat_sum  = sat_mul | (|sum_w[PROD_BITS:SQ_BITS]);

  assign m2_ext = MW'(m2_r);

  assign mem_we  = clearing || ((state_r == ST_DONE) && out_free && live_r);
  assign mem_wa  = clearing ? clr_idx_r : ch_idx_r;
  assign mean_wd = clearing ? '0 : m2_r;
  assign sq_wd   = clearing ? '0 : s2_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mean_mem[mem_wa] <= mean_wd;
      sq_mem[mem_wa]   <= sq_wd;
    end
    if (pop) begin
      mean_rd_r <= mean_mem[rd_idx];
      sq_rd_r   <= sq_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == CW'(CHANNELS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop_valid) begin
            live_r   <= pop_item.live;
            ch_r     <= pop_item.channel;
            ch_idx_r <= rd_idx;
            n_r      <= pop_item.count;
            x_r      <= x_in;
            state_r  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          m_r       <= m_cur;
          s_r       <= s_cur;
          neg_r     <= d1[DW-1];
          a_r       <= a_mag;
          quot_r    <= a_mag;
          rem_r     <= '0;
          div_cnt_r <= DCW'(DW - 1);
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          rem_r  <= div_ge ? rem_sub[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
          quot_r <= {quot_r[DW-2:0], div_ge};
          if (div_cnt_r == '0) begin
            state_r <= ST_ADJ;
          end else begin
            div_cnt_r <= div_cnt_r - 1'b1;
          end
        end
        ST_ADJ: begin
          m2_r    <= m2_calc;
          state_r <= ST_BDIF;
        end
        ST_BDIF: begin
          mul_b_r   <= BPW'(b_mag);
          acc_r     <= '0;
          mul_cnt_r <= MCW'(ND - 1);
          state_r   <= ST_MUL;
        end
        ST_MUL: begin
          acc_r   <= acc_step;
          mul_b_r <= mul_b_r << MUL_DIGIT;
          if (mul_cnt_r == '0) begin
            state_r <= ST_SUM;
          end else begin
            mul_cnt_r <= mul_cnt_r - 1'b1;
          end
        end
        ST_SUM: begin
          sat_r   <= sat_sum;
          s2_r    <= sat_sum ? SQ_MAX : sum_w[SQ_BITS-1:0];
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_ch_r    <= ch_r;
            out_mean_r  <= m2_ext[MEAN_OUT_BITS-1:0];
            out_sq_r    <= s2_r;
            out_sat_r   <= sat_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel_out    = out_ch_r;
  assign out_mean_out       = out_mean_r;
  assign out_sq_dev_sum_out = out_sq_r;
  assign out_saturated      = out_sat_r;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !pop)
    else $error("item taken from queue during clearing pass");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADJ) |-> (quot_r <= a_r))
    else $error("mean step larger than the deviation");

  a_first_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADJ && n_r == COUNT_BITS'(1)) |-> (quot_r == a_r))
    else $error("first sample does not take the full deviation");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> (out_sq_r == SQ_MAX))
    else $error("saturated result below the limit");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished item not presented");

endmodule

`default_nettype wire

[rtl/core/running_mean_variance_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// per-channel running mean and sum of squared deviations (welford update)
// input channel: in_valid / in_stall with in_channel, in_sample_index and
//   in_sample_value (signed q16.16); an item is taken when valid is high and
//   stall is low
// result channel: out_valid / out_stall with out_channel_out, out_mean_out,
//   out_sq_dev_sum_out (q31.32, saturating) and out_saturated; one result
//   per item, in order
// a front stage classifies each item and pushes it into a two-entry queue;
// the back unit updates one item at a time
// back unit per item: the radix-2 divider (one quotient bit a cycle), then
//   the 16-bit digit multiplier; it takes no new item from the queue until
//   the last one has left for the output register
// reset: after rst_n the store is cleared one channel a cycle, with in_stall
//   high the whole time
// receiver stall: the result waits in the output register, the back unit
//   holds its finished item and the queue keeps taking items until full
module running_mean_variance_core
  import rmv_pkg::*;
#(
  parameter int CHANNELS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [CH_BITS-1:0]            in_channel,
  input  wire logic [INDEX_BITS-1:0]         in_sample_index,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [CH_BITS-1:0]                 out_channel_out,
  output logic signed [MEAN_OUT_BITS-1:0]    out_mean_out,
  output logic [SQ_BITS-1:0]                 out_sq_dev_sum_out,
  output logic                               out_saturated
);

  // front to queue
  logic      push;
  rmv_item_t push_item;
  logic      q_full;

  // queue to back
  logic      pop;
  logic      pop_valid;
  rmv_item_t pop_item;

  // store clearing pass in progress
  logic      clearing;

  rmv_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_channel      (in_channel),
    .in_sample_index (in_sample_index),
    .in_sample_value (in_sample_value),
    .q_full          (q_full),
    .clearing        (clearing),
    .push            (push),
    .push_item       (push_item)
  );

  rmv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  // divider, multiplier, channel store and output register
  rmv_back #(
    .CHANNELS   (CHANNELS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_item           (pop_item),
    .pop                (pop),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel_out    (out_channel_out),
    .out_mean_out       (out_mean_out),
    .out_sq_dev_sum_out (out_sq_dev_sum_out),
    .out_saturated      (out_saturated)
  );

endmodule

`default_nettype wire

[tb/running_mean_variance_core_tb.sv]
`timescale 1ns / 1ps

module running_mean_variance_core_tb
  import rmv_pkg::*;
();

  localparam int NUM_CH     = 64;
  localparam int VAL_BITS   = 32;
  localparam int MAX_REPORT = 10;

  localparam logic signed [SAMPLE_BITS-1:0] VAL_MIN  = 32'sh8000_0000;
  localparam logic signed [SAMPLE_BITS-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
  localparam logic [INDEX_BITS-1:0]         IDX_LAST = 32'hFFFF_FFFF;

  // receiver behavior, picked anew at random when the current mode runs out
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // one expected welford update as the core should return it
  typedef struct {
    logic [CH_BITS-1:0]              channel;
    logic signed [MEAN_OUT_BITS-1:0] mean;
    logic [SQ_BITS-1:0]              sq_dev_sum;
    logic                            saturated;
  } welford_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [CH_BITS-1:0]            in_channel;
  logic [INDEX_BITS-1:0]         in_sample_index;
  logic signed [SAMPLE_BITS-1:0] in_sample_value;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [CH_BITS-1:0]            out_channel_out;
  logic signed [MEAN_OUT_BITS-1:0] out_mean_out;
  logic [SQ_BITS-1:0]            out_sq_dev_sum_out;
  logic                          out_saturated;

  // predictor state: per-channel mean and deviation sum, cleared like the core
  logic signed [SAMPLE_BITS-1:0] mean_acc [NUM_CH];
  logic [SQ_BITS-1:0]            sq_acc [NUM_CH];
  welford_result_t               expected_updates [$];

  // per-channel sequence state for the random part
  logic [INDEX_BITS-1:0]         next_index [NUM_CH];
  logic signed [SAMPLE_BITS-1:0] channel_center [NUM_CH];

  int mismatch_count;
  int burst_left;

  running_mean_variance_core #(
    .CHANNELS   (NUM_CH),
    .VALUE_BITS (VAL_BITS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_channel         (in_channel),
    .in_sample_index    (in_sample_index),
    .in_sample_value    (in_sample_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel_out    (out_channel_out),
    .out_mean_out       (out_mean_out),
    .out_sq_dev_sum_out (out_sq_dev_sum_out),
    .out_saturated      (out_saturated)
  );

  // 12 ns clock, starts low
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // welford update on the local copy of the store:
  //   d1 = x - m, m' = m + d1 / n (truncated toward zero), S' = S + |d1| * |x - m'|
  // the sum clamps at its top value and flags saturation
  task automatic predict_welford_update(input logic [CH_BITS-1:0] ch,
                                        input logic [INDEX_BITS-1:0] idx,
                                        input logic signed [SAMPLE_BITS-1:0] val);
    longint          x;
    longint          m;
    longint          d1;
    longint          m2;
    longint          d2;
    logic [32:0]     divisor;
    logic [63:0]     a;
    logic [63:0]     b;
    logic [63:0]     q;
    logic [127:0]    total;
    welford_result_t r;
    x       = val;
    m       = mean_acc[ch];
    divisor = {1'b0, idx} + 33'd1;  // one bit wider than the index, so never zero
    d1      = x - m;
    a       = (d1 < 0) ? -d1 : d1;
    q       = a / divisor;
    m2      = (d1 < 0) ? m - longint'(q) : m + longint'(q);
    d2      = x - m2;
    b       = (d2 < 0) ? -d2 : d2;
    total   = 128'(sq_acc[ch]) + 128'(a) * 128'(b);
    r.channel = ch;
    r.mean    = m2[MEAN_OUT_BITS-1:0];
    if (total > 128'(SQ_MAX)) begin
      r.sq_dev_sum = SQ_MAX;
      r.saturated  = 1'b1;
    end else begin
      r.sq_dev_sum = total[SQ_BITS-1:0];
      r.saturated  = 1'b0;
    end
    mean_acc[ch] = r.mean;
    sq_acc[ch]   = r.sq_dev_sum;
    expected_updates.insert(expected_updates.size(), r);
  endtask

  // drive one item at the falling edge, hold it until taken, then maybe
  // open a gap before the next burst
  task automatic send_item(input logic [CH_BITS-1:0] ch,
                           input logic [INDEX_BITS-1:0] idx,
                           input logic signed [SAMPLE_BITS-1:0] val);
    int gap;
    int pick;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_channel      <= ch;
    in_sample_index <= idx;
    in_sample_value <= val;
    do @(posedge clk); while (in_stall);
    predict_welford_update(ch, idx, val);
    burst_left--;
    if (burst_left <= 0) begin
      pick = $urandom_range(0, 9);
      // short bursts mostly, now and then a long stretch with no gaps
      if (pick < 5)      burst_left = $urandom_range(1, 8);
      else if (pick < 8) burst_left = $urandom_range(9, 40);
      else               burst_left = $urandom_range(100, 300);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // receiver stall pattern, changed at the falling edge
  stall_mode_t stall_mode   = STALL_NONE;
  int          stall_left   = 0;
  int          stall_period = 8;
  int          stall_duty   = 4;
  int          stall_cycle  = 0;

  always @(negedge clk) begin
    if (stall_left <= 0) begin
      stall_mode   <= stall_mode_t'($urandom_range(0, 3));
      stall_left   <= $urandom_range(20, 400);
      stall_period <= $urandom_range(2, 40);
      stall_duty   <= $urandom_range(1, 39);
      out_stall    <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall <= ((stall_cycle % stall_period) < stall_duty);
        default:        out_stall <= 1'b0;
      endcase
    end
    stall_cycle <= stall_cycle + 1;
  end

  // result check: every taken result against the oldest expected update
  always @(posedge clk) begin
    welford_result_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_updates.size() == 0) begin
        if (mismatch_count < MAX_REPORT)
          $display("unexpected result: ch %0d mean %h sum %h sat %b",
                   out_channel_out, out_mean_out, out_sq_dev_sum_out, out_saturated);
        mismatch_count++;
      end else begin
        r = expected_updates.pop_front();
        if (out_channel_out !== r.channel || out_mean_out !== r.mean ||
            out_sq_dev_sum_out !== r.sq_dev_sum || out_saturated !== r.saturated) begin
          if (mismatch_count < MAX_REPORT) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected: ch %0d mean %h sum %h sat %b",
                     r.channel, r.mean, r.sq_dev_sum, r.saturated);
            $display("  actual:   ch %0d mean %h sum %h sat %b",
                     out_channel_out, out_mean_out, out_sq_dev_sum_out, out_saturated);
          end
          mismatch_count++;
        end
      end
    end
  end

  // first sample of a channel: divisor one, mean takes the value, sum unchanged
  task automatic test_first_samples();
    send_item(6'd0, 32'd0, VAL_MAX);
    send_item(6'd63, 32'd0, VAL_MIN);
    send_item(6'd1, 32'd0, 32'sd0);
    send_item(6'd2, 32'd0, -32'sd1);
  endtask

  // division truncates toward zero on both signs; large divisors leave the mean
  task automatic test_truncation();
    send_item(6'd7, 32'd0, 32'sd0);
    send_item(6'd7, 32'd2, -32'sd5);
    send_item(6'd7, 32'd2, 32'sd5);
    send_item(6'd7, 32'd3, -32'sd7);
    send_item(6'd7, IDX_LAST, 32'sh4000_0000);  // divisor of 2^32
    send_item(6'd7, 32'hFFFF_FFFE, VAL_MAX);
    // restart a populated channel at index zero
    send_item(6'd7, 32'd0, 32'sd3);
  endtask

  // deviation sum runs into its limit and stays there
  task automatic test_saturation();
    send_item(6'd5, 32'd0, VAL_MIN);
    send_item(6'd5, 32'd1, VAL_MAX);             // just below the limit
    send_item(6'd5, 32'd1, VAL_MIN);             // over the limit, clamps
    send_item(6'd5, 32'd5, 32'shC000_0000);      // value equals mean: zero product
    send_item(6'd5, 32'd6, VAL_MAX);             // at limit, clamps again
    send_item(6'd9, 32'd0, VAL_MIN);
    send_item(6'd9, 32'd1, VAL_MAX);
    send_item(6'd9, 32'd1, VAL_MAX);
  endtask

  // extremes of index and channel fields
  task automatic test_extremes();
    send_item(6'd63, IDX_LAST, VAL_MAX);
    send_item(6'd0, 32'h8000_0000, VAL_MIN);
    send_item(6'd42, 32'h5555_5555, 32'shAAAA_AAAA);
    send_item(6'd21, 32'hAAAA_AAAA, 32'sh5555_5555);
    send_item(6'd63, 32'd1, 32'sd1);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input int ch);
    int pick;
    int spread;
    pick   = $urandom_range(0, 99);
    spread = 1 << $urandom_range(4, 22);
    if (pick < 45)
      return channel_center[ch] + $urandom_range(0, 2 * spread) - spread;
    else if (pick < 65)
      return $urandom;
    else if (pick < 75) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end else
      return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
  endfunction

  // mostly in-order sample sequences per channel around a channel center,
  // with restarts and out-of-sequence indexes as noise
  task automatic test_random_sequences(input int n_items);
    int                    k;
    int                    ch;
    int                    pick;
    logic [INDEX_BITS-1:0] idx;
    for (k = 0; k < NUM_CH; k++) begin
      next_index[k]     = '0;
      channel_center[k] = $urandom >>> $urandom_range(0, 12);
    end
    for (k = 0; k < n_items; k++) begin
      ch   = $urandom_range(0, NUM_CH - 1);
      pick = $urandom_range(0, 99);
      if (pick < 3)
        next_index[ch] = '0;
      if (pick >= 3 && pick < 10) begin
        idx = $urandom;
      end else begin
        idx            = next_index[ch];
        next_index[ch] = next_index[ch] + 1;
      end
      send_item(ch[CH_BITS-1:0], idx, draw_sample(ch));
    end
  endtask

  // generous fixed limit on the whole run
  initial begin
    #(12_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int waited;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_channel      = '0;
    in_sample_index = '0;
    in_sample_value = '0;
    mismatch_count  = 0;
    burst_left      = 1;
    waited          = 0;
    for (int k = 0; k < NUM_CH; k++) begin
      mean_acc[k] = '0;
      sq_acc[k]   = '0;
    end

    // reset first; the core clears its store afterwards with in_stall high
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_samples();
    test_truncation();
    test_saturation();
    test_extremes();
    test_random_sequences(1450);

    @(negedge clk);
    in_valid <= 1'b0;

    // drain: every expected update must come back
    while (expected_updates.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    // leave room for a stray result after the expected list empties
    repeat (100) @(posedge clk);

    if (expected_updates.size() != 0) begin
      if (mismatch_count < MAX_REPORT)
        $display("%0d expected results never arrived", expected_updates.size());
      mismatch_count++;
    end

    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rmv_pkg.sv
rtl/core/rmv_front.sv
rtl/core/rmv_queue.sv
rtl/core/rmv_back.sv
rtl/core/running_mean_variance_core.sv
tb/running_mean_variance_core_tb.sv
